// File: sv/tnmh_pkg.sv
// tnmh_pkg: shared types and constants of the top-n min-heap block
// no dependencies; imported by every module of the block but tnmh_ram
`default_nettype none

package tnmh_pkg;

    // default heap capacity in entries
    localparam int CAPACITY_DEF = 64;

    // field widths
    localparam int HEAP_SIZE_W = 7;
    localparam int OP_W        = 2;
    localparam int INDEX_W     = 6;
    localparam int VALUE_W     = 32;

    // stream widths
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 64;
    localparam int M_TUSER_W = 2;

    // heap size after reset
    localparam logic [HEAP_SIZE_W-1:0] HEAP_SIZE_RST = 7'd64;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_BUILD = 2'd1,
        OP_OFFER = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_BLD_RD,
        ST_BLD_LD,
        ST_SIFT_L,
        ST_SIFT_R,
        ST_SIFT_CMP,
        ST_SIFT_FIN,
        ST_RESULT
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic take_in;
        logic load_write;
        logic read_issue;
        logic start_offer;
        logic start_build;
        logic bld_issue;
        logic bld_load;
        logic sl_step;
        logic sr_step;
        logic cmp_step;
        logic fin_write;
        logic i_dec;
        logic out_load;
    } ctrl_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        op_t  op;
        logic offer_gt;
        logic l_ok;
        logic move;
        logic nl_ok;
        logic i_zero;
        logic out_busy;
    } dp_status_t;

endpackage

`default_nettype wire

// File: sv/top_n_min_heap.sv
// top_n_min_heap: top level, heap size register and controller/datapath pair
// depends on tnmh_pkg, tnmh_ctrl, tnmh_dp
`default_nettype none

// Keeps the N largest 32-bit values in a binary min-heap held in one
// single-read-port RAM; every result beat reports the current root. One item is
// handled at a time. An accepted offer moves the new root down level by level,
// each level reading its two children one after the other through the RAM read
// port (at most 6 levels for 64 entries). A build runs one such sift for every
// node from N/2 down to the root, fetching each node from the RAM first. The
// next item can be accepted in the cycle after the result beat is loaded, while
// that beat still waits. There is no clearing pass after reset: entries must be
// loaded before they are read, built over or offered against.
module top_n_min_heap #(
    parameter int CAPACITY = tnmh_pkg::CAPACITY_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // heap size register write
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tnmh_pkg::HEAP_SIZE_W-1:0]   cfg_data,
    // input beat
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [tnmh_pkg::S_TDATA_W-1:0]     s_tdata,   // index[5:0], value[37:6], zero
    input  logic [tnmh_pkg::OP_W-1:0]          s_tuser,   // operation[1:0]
    // result beat
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [tnmh_pkg::M_TDATA_W-1:0]     m_tdata,   // read_value[31:0], heap_minimum[63:32]
    output logic [tnmh_pkg::M_TUSER_W-1:0]     m_tuser    // accepted[0], index_error[1]
);
    import tnmh_pkg::*;

    logic [HEAP_SIZE_W-1:0] heap_size_reg;
    logic [HEAP_SIZE_W-1:0] heap_size_next;
    ctrl_cmd_t              cmd;
    dp_status_t             status;

    // heap size register, always ready
    assign cfg_ready      = 1'b1;
    assign heap_size_next = (cfg_valid && cfg_ready) ? cfg_data : heap_size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_size_reg <= HEAP_SIZE_RST;
        end
        else
        begin
            heap_size_reg <= heap_size_next;
        end
    end

    tnmh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tnmh_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .heap_size (heap_size_reg),
        .operation (s_tuser),
        .index     (s_tdata[INDEX_W-1:0]),
        .value     (s_tdata[INDEX_W+VALUE_W-1:INDEX_W]),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

// File: sv/tnmh_ram.sv
// tnmh_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
`default_nettype none

module tnmh_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: sv/tnmh_ctrl.sv
// tnmh_ctrl: controller state machine of the top-n min-heap
// depends on tnmh_pkg
`default_nettype none

module tnmh_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  tnmh_pkg::dp_status_t   status,
    output tnmh_pkg::ctrl_cmd_t    cmd
);
    import tnmh_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        logic build_more;
        build_more = (status.op == OP_BUILD) && !status.i_zero;
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.take_in = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                unique case (status.op)
                    OP_LOAD:
                    begin
                        cmd.load_write = 1'b1;
                        state_next     = ST_RESULT;
                    end
                    OP_READ:
                    begin
                        cmd.read_issue = 1'b1;
                        state_next     = ST_RESULT;
                    end
                    OP_OFFER:
                    begin
                        if (status.offer_gt)
                        begin
                            cmd.start_offer = 1'b1;
                            state_next      = ST_SIFT_L;
                        end
                        else
                        begin
                            state_next = ST_RESULT;
                        end
                    end
                    OP_BUILD:
                    begin
                        cmd.start_build = 1'b1;
                        state_next      = ST_BLD_RD;
                    end
                    default:
                    begin
                        state_next = ST_RESULT;
                    end
                endcase
            end
            ST_BLD_RD:
            begin
                cmd.bld_issue = 1'b1;
                state_next    = ST_BLD_LD;
            end
            ST_BLD_LD:
            begin
                cmd.bld_load = 1'b1;
                state_next   = ST_SIFT_L;
            end
            ST_SIFT_L:
            begin
                cmd.sl_step = 1'b1;
                if (status.l_ok)
                begin
                    state_next = ST_SIFT_R;
                end
                else if (build_more)
                begin
                    cmd.i_dec  = 1'b1;
                    state_next = ST_BLD_RD;
                end
                else
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_SIFT_R:
            begin
                cmd.sr_step = 1'b1;
                state_next  = ST_SIFT_CMP;
            end
            ST_SIFT_CMP:
            begin
                cmd.cmp_step = 1'b1;
                if (status.move)
                begin
                    state_next = status.nl_ok ? ST_SIFT_R : ST_SIFT_FIN;
                end
                else if (build_more)
                begin
                    cmd.i_dec  = 1'b1;
                    state_next = ST_BLD_RD;
                end
                else
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_SIFT_FIN:
            begin
                cmd.fin_write = 1'b1;
                if (build_more)
                begin
                    cmd.i_dec  = 1'b1;
                    state_next = ST_BLD_RD;
                end
                else
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: sv/tnmh_dp.sv
// tnmh_dp: datapath of the top-n min-heap, heap ram, sift registers, output beat register
// depends on tnmh_pkg and tnmh_ram
`default_nettype none

module tnmh_dp #(
    parameter int CAPACITY = tnmh_pkg::CAPACITY_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [tnmh_pkg::HEAP_SIZE_W-1:0]    heap_size,
    input  logic [tnmh_pkg::OP_W-1:0]           operation,
    input  logic [tnmh_pkg::INDEX_W-1:0]        index,
    input  logic [tnmh_pkg::VALUE_W-1:0]        value,
    input  tnmh_pkg::ctrl_cmd_t                 cmd,
    output tnmh_pkg::dp_status_t                status,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [tnmh_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [tnmh_pkg::M_TUSER_W-1:0]      m_tuser
);
    import tnmh_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int NW = $clog2(CAPACITY + 1);
    localparam int XW = AW + 2;

    // item and sift registers
    op_t                  op_reg;
    logic [INDEX_W-1:0]   idx_reg;
    logic [VALUE_W-1:0]   val_reg;
    logic [NW-1:0]        n_reg;
    logic [AW-1:0]        node_reg;
    logic [VALUE_W-1:0]   v_reg;
    logic [VALUE_W-1:0]   lval_reg;
    logic                 rok_reg;
    logic [AW-1:0]        i_reg;
    logic [VALUE_W-1:0]   root_reg;
    logic                 acc_reg;
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TUSER_W-1:0] m_tuser_reg;

    // ram port
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [VALUE_W-1:0]   ram_wdata;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    logic [VALUE_W-1:0]   ram_rdata;

    // derived values
    logic [NW-1:0]        n_eff;
    logic                 idx_ok;
    logic                 err;
    logic [XW-1:0]        l_full;
    logic [XW-1:0]        r_full;
    logic                 l_ok;
    logic                 r_ok;
    logic                 r_pick;
    logic [AW-1:0]        child;
    logic [VALUE_W-1:0]   cval;
    logic                 move;
    logic [XW-1:0]        nl_full;
    logic                 nl_ok;
    logic [VALUE_W-1:0]   rd_val;
    logic                 out_busy;

    tnmh_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_heap_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // heap size saturated into 1..capacity
    always_comb
    begin
        if (heap_size == '0)
        begin
            n_eff = NW'(1);
        end
        else if (32'(heap_size) > 32'(CAPACITY))
        begin
            n_eff = NW'(CAPACITY);
        end
        else
        begin
            n_eff = NW'(heap_size);
        end
    end

    // index check and child positions
    assign idx_ok  = 32'(idx_reg) < 32'(n_reg);
    assign err     = ((op_reg == OP_LOAD) || (op_reg == OP_READ)) && !idx_ok;
    assign l_full  = {1'b0, node_reg, 1'b1};
    assign r_full  = l_full + XW'(1);
    assign l_ok    = 32'(l_full) < 32'(n_reg);
    assign r_ok    = 32'(r_full) < 32'(n_reg);

    // smaller child, left wins a tie
    assign r_pick  = rok_reg && (ram_rdata < lval_reg);
    assign child   = r_pick ? r_full[AW-1:0] : l_full[AW-1:0];
    assign cval    = r_pick ? ram_rdata : lval_reg;
    assign move    = cval < v_reg;
    assign nl_full = {1'b0, child, 1'b1};
    assign nl_ok   = 32'(nl_full) < 32'(n_reg);

    assign rd_val   = ((op_reg == OP_READ) && idx_ok) ? ram_rdata : '0;
    assign out_busy = m_tvalid_reg && !m_tready;

    // ram port select
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = node_reg;
        ram_wdata = v_reg;
        ram_re    = 1'b0;
        ram_raddr = l_full[AW-1:0];
        if (cmd.load_write)
        begin
            ram_we    = idx_ok;
            ram_waddr = AW'(idx_reg);
            ram_wdata = val_reg;
        end
        if (cmd.read_issue)
        begin
            ram_re    = idx_ok;
            ram_raddr = AW'(idx_reg);
        end
        if (cmd.bld_issue)
        begin
            ram_re    = 1'b1;
            ram_raddr = i_reg;
        end
        if (cmd.sl_step)
        begin
            ram_re = l_ok;
            ram_we = !l_ok;
        end
        if (cmd.sr_step)
        begin
            ram_re    = r_ok;
            ram_raddr = r_full[AW-1:0];
        end
        if (cmd.cmp_step)
        begin
            ram_we    = 1'b1;
            ram_wdata = move ? cval : v_reg;
            ram_re    = move && nl_ok;
            ram_raddr = nl_full[AW-1:0];
        end
        if (cmd.fin_write)
        begin
            ram_we = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg       <= OP_LOAD;
            acc_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.take_in)
            begin
                op_reg  <= op_t'(operation);
                acc_reg <= 1'b0;
            end
            else if (cmd.start_offer)
            begin
                acc_reg <= 1'b1;
            end
            if (cmd.out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.take_in)
        begin
            idx_reg <= index;
            val_reg <= value;
            n_reg   <= n_eff;
        end
        if (cmd.start_offer)
        begin
            v_reg    <= val_reg;
            node_reg <= '0;
        end
        if (cmd.start_build)
        begin
            i_reg <= AW'(n_reg >> 1);
        end
        else if (cmd.i_dec)
        begin
            i_reg <= i_reg - AW'(1);
        end
        if (cmd.bld_load)
        begin
            v_reg    <= ram_rdata;
            node_reg <= i_reg;
        end
        if (cmd.sr_step)
        begin
            lval_reg <= ram_rdata;
            rok_reg  <= r_ok;
        end
        if (cmd.cmp_step && move)
        begin
            node_reg <= child;
        end
        // shadow copy of the root entry
        if (ram_we && (ram_waddr == '0))
        begin
            root_reg <= ram_wdata;
        end
        if (cmd.out_load)
        begin
            m_tdata_reg <= {root_reg, rd_val};
            m_tuser_reg <= {err, acc_reg};
        end
    end

    // status to controller
    always_comb
    begin
        status.op       = op_reg;
        status.offer_gt = val_reg > root_reg;
        status.l_ok     = l_ok;
        status.move     = move;
        status.nl_ok    = nl_ok;
        status.i_zero   = (i_reg == '0);
        status.out_busy = out_busy;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ram never reads the slot it writes in the same cycle
    a_ram_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("heap ram read and write at the same address");

    // a new result never overwrites one still waiting
    a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !out_busy)
        else $error("result register overwritten while stalled");

    // an accepted offer never carries an index error
    a_acc_no_err: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && acc_reg) |-> !err)
        else $error("accepted and index error both set");

endmodule

`default_nettype wire

// File: dv/heap_checker.sv
// heap_checker: watches the config, input and result channels of top_n_min_heap,
// mirrors the heap to predict every result beat and compares it field by field
// depends on tnmh_pkg
module heap_checker
    import tnmh_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [HEAP_SIZE_W-1:0] cfg_data,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // index[5:0], value[37:6], zero
    input  logic [OP_W-1:0]        s_tuser,   // operation[1:0]
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [M_TDATA_W-1:0]   m_tdata,   // read_value[31:0], heap_minimum[63:32]
    input  logic [M_TUSER_W-1:0]   m_tuser,   // accepted[0], index_error[1]
    output int unsigned            fail_count,
    output int unsigned            pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [VALUE_W-1:0] read_value;
        logic [VALUE_W-1:0] heap_minimum;
        logic               accepted;
        logic               index_error;
    } heap_result_t;

    // mirror of the heap store and the size register
    logic [VALUE_W-1:0]     heap_mem [CAPACITY_DEF];
    logic [HEAP_SIZE_W-1:0] heap_size_reg;
    heap_result_t           expected_q [$];

    // size register saturated into 1..capacity
    function automatic int live_entries();
        if (heap_size_reg == '0)
            return 1;
        if (int'(heap_size_reg) > CAPACITY_DEF)
            return CAPACITY_DEF;
        return int'(heap_size_reg);
    endfunction

    // move an entry down until both children are not smaller
    function automatic void sift_down(input int start, input int n);
        int                 node;
        int                 lc;
        int                 rc;
        int                 m;
        bit                 done;
        logic [VALUE_W-1:0] t;
        node = start;
        done = 1'b0;
        while (!done)
        begin
            lc = 2 * node + 1;
            rc = lc + 1;
            m  = node;
            if (lc < n && heap_mem[lc] < heap_mem[m])
                m = lc;
            if (rc < n && heap_mem[rc] < heap_mem[m])
                m = rc;
            if (m == node)
                done = 1'b1;
            else
            begin
                t              = heap_mem[m];
                heap_mem[m]    = heap_mem[node];
                heap_mem[node] = t;
                node           = m;
            end
        end
    endfunction

    // apply one input beat to the mirror and return the result it causes
    function automatic heap_result_t predict_result(input op_t op,
                                                    input logic [INDEX_W-1:0] idx,
                                                    input logic [VALUE_W-1:0] val);
        heap_result_t res;
        int           n;
        n   = live_entries();
        res = '0;
        case (op)
            OP_LOAD:
            begin
                if (int'(idx) < n)
                    heap_mem[idx] = val;
                else
                    res.index_error = 1'b1;
            end
            OP_BUILD:
            begin
                for (int i = n / 2; i >= 0; i--)
                    sift_down(i, n);
            end
            OP_OFFER:
            begin
                if (val > heap_mem[0])
                begin
                    heap_mem[0] = val;
                    sift_down(0, n);
                    res.accepted = 1'b1;
                end
            end
            default:
            begin
                if (int'(idx) < n)
                    res.read_value = heap_mem[idx];
                else
                    res.index_error = 1'b1;
            end
        endcase
        res.heap_minimum = heap_mem[0];
        return res;
    endfunction

    function automatic int check_field(input string name, input logic [VALUE_W-1:0] want,
                                       input logic [VALUE_W-1:0] got);
        if (want !== got)
        begin
            $error("%s expected %0h actual %0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // compare result beats, then predict from config and input beats
    always @(posedge clk or negedge rst_n)
    begin : watch
        heap_result_t got;
        heap_result_t want;
        int           errs;
        if (!rst_n)
        begin
            for (int k = 0; k < CAPACITY_DEF; k++)
                heap_mem[k] = '0;
            heap_size_reg = HEAP_SIZE_RST;
            expected_q.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            errs = 0;
            if (m_tvalid && m_tready)
            begin
                got.read_value   = m_tdata[VALUE_W-1:0];
                got.heap_minimum = m_tdata[2*VALUE_W-1:VALUE_W];
                got.accepted     = m_tuser[0];
                got.index_error  = m_tuser[1];
                if (expected_q.size() == 0)
                begin
                    $error("result beat with no expected result waiting");
                    errs++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    errs += check_field("read_value", want.read_value, got.read_value);
                    errs += check_field("heap_minimum", want.heap_minimum,
                                        got.heap_minimum);
                    errs += check_field("accepted", 32'(want.accepted), 32'(got.accepted));
                    errs += check_field("index_error", 32'(want.index_error),
                                        32'(got.index_error));
                end
            end
            if (cfg_valid && cfg_ready)
                heap_size_reg = cfg_data;
            if (s_tvalid && s_tready)
                expected_q.push_back(predict_result(op_t'(s_tuser),
                                                    s_tdata[INDEX_W-1:0],
                                                    s_tdata[INDEX_W+VALUE_W-1:INDEX_W]));
            fail_count <= fail_count + errs;
            pending    <= expected_q.size();
        end
    end

endmodule

// File: dv/tb.sv
// tb: stimulus and verdict for top_n_min_heap; directed heap cases, then random
// phases of load, build, offer and read beats at several heap sizes
// depends on tnmh_pkg, top_n_min_heap and heap_checker
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tnmh_pkg::*;

    localparam int SETTLE_CYCLES = 20;
    localparam int FEED_TARGET   = 900;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic [HEAP_SIZE_W-1:0] cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;   // index[5:0], value[37:6], zero
    logic [OP_W-1:0]        s_tuser   = '0;   // operation[1:0]
    logic                   m_tready  = 1'b0;
    logic                   cfg_ready;
    logic                   s_tready;
    logic                   m_tvalid;
    logic [M_TDATA_W-1:0]   m_tdata;          // read_value[31:0], heap_minimum[63:32]
    logic [M_TUSER_W-1:0]   m_tuser;          // accepted[0], index_error[1]

    int unsigned        fail_count;
    int unsigned        pending;
    int                 feed_count;
    logic               quiet    = 1'b0;
    logic [VALUE_W-1:0] ramp_val = '0;

    top_n_min_heap DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    heap_checker heap_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #2 clk = ~clk;

    // result side stalls at random unless in a quiet stretch
    always @(posedge clk)
        m_tready <= quiet || ($urandom_range(99) >= 26);

    function automatic bit idle_now();
        return !quiet && ($urandom_range(99) < 26);
    endfunction

    // mix of wide, tiny, near-max and rising values so ties and takeovers occur
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(9))
            0, 1, 2: return $urandom();
            3, 4, 5: return $urandom_range(31);
            6, 7:    return 32'hFFFF_FFFF - $urandom_range(15);
            default:
            begin
                ramp_val = ramp_val + $urandom_range(9, 1);
                return ramp_val;
            end
        endcase
    endfunction

    // one input beat, with random gaps before it
    task automatic send_item(input op_t op, input logic [INDEX_W-1:0] idx,
                             input logic [VALUE_W-1:0] val);
        while (idle_now())
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, val, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_heap_size(input logic [HEAP_SIZE_W-1:0] size);
        s_tvalid <= 1'b0;
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= size;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // fill every live entry, build, then a random mix dominated by offers
    task automatic run_phase(input logic [HEAP_SIZE_W-1:0] size, input int ops);
        int                 n;
        int                 pick;
        logic [INDEX_W-1:0] idx;
        write_heap_size(size);
        n = (size == '0) ? 1 : ((int'(size) > CAPACITY_DEF) ? CAPACITY_DEF : int'(size));
        for (int k = 0; k < n; k++)
        begin
            send_item(OP_LOAD, INDEX_W'(k), pick_value());
            feed_count++;
        end
        send_item(OP_BUILD, INDEX_W'($urandom()), $urandom());
        feed_count++;
        for (int k = 0; k < ops; k++)
        begin
            pick = $urandom_range(99);
            if (pick < 68)
            begin
                send_item(OP_OFFER, INDEX_W'($urandom()), pick_value());
                feed_count++;
            end
            else if (pick < 80)
            begin
                send_item(OP_READ, INDEX_W'($urandom_range(n - 1)), $urandom());
                feed_count++;
            end
            else if (pick < 86)
            begin
                send_item(OP_LOAD, INDEX_W'($urandom_range(n - 1)), pick_value());
                feed_count++;
            end
            else if (pick < 90)
            begin
                send_item(OP_BUILD, INDEX_W'($urandom()), $urandom());
                feed_count++;
            end
            else if (n < CAPACITY_DEF)
            begin
                // index past the live size, flagged and ignored
                idx = INDEX_W'($urandom_range(CAPACITY_DEF - 1, n));
                send_item($urandom_range(1) ? OP_LOAD : OP_READ, idx, $urandom());
                feed_count++;
            end
            else
            begin
                send_item(OP_READ, INDEX_W'($urandom()), $urandom());
                feed_count++;
            end
        end
    endtask

    initial
    begin
        logic [HEAP_SIZE_W-1:0] sizes [7];
        int                     phase;
        sizes = '{7'd64, 7'd0, 7'd127, 7'd1, 7'd2, 7'd63, 7'd65};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // size zero acts as one entry
        write_heap_size(7'd0);
        send_item(OP_LOAD, 6'd0, 32'hA5A5_5A5A);
        send_item(OP_LOAD, 6'd1, 32'h1234_5678);
        send_item(OP_READ, 6'd0, '0);
        send_item(OP_READ, 6'd63, '0);
        send_item(OP_OFFER, 6'd0, 32'hFFFF_FFFF);

        // four entries holding both value extremes
        write_heap_size(7'd4);
        send_item(OP_LOAD, 6'd0, 32'hFFFF_FFFF);
        send_item(OP_LOAD, 6'd1, 32'h0000_0000);
        send_item(OP_LOAD, 6'd2, 32'd5);
        send_item(OP_LOAD, 6'd3, 32'd7);
        send_item(OP_LOAD, 6'd4, 32'd9);
        send_item(OP_BUILD, 6'd63, 32'hFFFF_FFFF);
        send_item(OP_READ, 6'd0, '0);
        // offer equal to the root is refused
        send_item(OP_OFFER, 6'd0, 32'd0);
        send_item(OP_OFFER, 6'd0, 32'd6);
        send_item(OP_OFFER, 6'd0, 32'hFFFF_FFFF);
        send_item(OP_OFFER, 6'd0, 32'd6);
        send_item(OP_READ, 6'd0, '0);
        send_item(OP_READ, 6'd1, '0);
        send_item(OP_READ, 6'd2, '0);
        send_item(OP_READ, 6'd3, 32'hFFFF_FFFF);

        // random phases, the one at size 127 (saturated to full size) without any stalls
        feed_count = 0;
        phase      = 0;
        while (feed_count < FEED_TARGET)
        begin
            quiet <= (phase == 2);
            if (phase < 7)
                run_phase(sizes[phase], $urandom_range(90, 40));
            else if ($urandom_range(9) < 7)
                run_phase(HEAP_SIZE_W'($urandom_range(16, 1)), $urandom_range(90, 40));
            else
                run_phase(HEAP_SIZE_W'($urandom_range(127)), $urandom_range(90, 40));
            phase++;
        end
        quiet    <= 1'b0;
        s_tvalid <= 1'b0;
        wait_drained();

        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
